### rtl/core/iis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types and constants of the interpolating image sampler.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int PIX_W   = 16;  // stored pixel width
  localparam int FRAC_W  = 8;   // fraction bits of coordinates and results
  localparam int COORD_W = 20;  // signed coordinate width
  localparam int OUT_W   = 26;  // signed result width
  localparam int POS_W   = 8;   // column / row index width
  localparam int ADDR_W  = 2 * POS_W;
  localparam int SIZE_W  = 9;   // image size register width
  localparam int IDX_W   = 13;  // signed neighbor index width
  localparam int WGT_W   = 27;  // signed tap weight width
  localparam int ROW_W   = 29;  // signed row partial result width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Pixel size limit of the store
  localparam logic [SIZE_W-1:0] MAX_SIZE = 9'd256;

  // Request commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Interpolation modes
  localparam logic [1:0] MODE_NEAREST = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_CUBIC   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WGT,
    S_FETCH,
    S_WAIT,
    S_DONE
  } iis_state_t;

  // Control that travels with each pixel read
  typedef struct packed {
    logic                    valid;
    logic                    fill;       // use fill value instead of memory data
    logic                    row_end;    // last tap of a row (or of a whole sum)
    logic                    last;       // last tap of the request
    logic                    cubic;      // row results go through vertical pass
    logic signed [WGT_W-1:0] weight;     // horizontal tap weight
    logic signed [WGT_W-1:0] row_weight; // vertical weight of this row
  } tap_tag_t;

  // Saturate to the signed result range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] maxv;
    logic signed [63:0] minv;
    maxv = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    minv = -(64'sd1 <<< (OUT_W - 1));
    if (v > maxv) return maxv[OUT_W-1:0];
    if (v < minv) return minv[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

endpackage

### rtl/core/iis_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_mem
// Single-port image store, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module iis_mem import iis_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] store [1 << ADDR_W];

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= wdata;
    end
    rdata <= store[addr];
  end

endmodule

### rtl/core/iis_wgt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_wgt
// Tap weight generator: bilinear and Catmull-Rom weights from the fractions.
// ----------------------------------------------------------------------------
module iis_wgt import iis_pkg::*; (
  input  logic                    clk,
  input  logic [FRAC_W-1:0]       fx,
  input  logic [FRAC_W-1:0]       fy,
  output logic signed [WGT_W-1:0] wx [4],
  output logic signed [WGT_W-1:0] wy [4],
  output logic signed [WGT_W-1:0] wl [4]
);

  localparam int SQ_W = 2 * FRAC_W;
  localparam int CU_W = 3 * FRAC_W;
  localparam int LW_W = 2 * (FRAC_W + 1);

  logic [SQ_W-1:0] fx2, fy2;
  logic [CU_W-1:0] fx3, fy3;
  logic [FRAC_W:0] sx, sy;
  logic [LW_W-1:0] l0, l1, l2, l3;

  // Catmull-Rom weight k, scaled by 2 S^3
  function automatic logic signed [WGT_W-1:0] cr_wgt(
    input logic [FRAC_W-1:0] f, input logic [SQ_W-1:0] f2,
    input logic [CU_W-1:0] f3, input logic [1:0] k);
    logic signed [WGT_W:0] a, a2, a3, r;
    a  = (WGT_W+1)'(f);
    a2 = (WGT_W+1)'(f2);
    a3 = (WGT_W+1)'(f3);
    unique case (k)
      2'd0: r = (a2 <<< (FRAC_W + 1)) - (a <<< SQ_W) - a3;
      2'd1: r = ((WGT_W+1)'(1) <<< (CU_W + 1)) - ((a2 * (WGT_W+1)'(5)) <<< FRAC_W)
                + a3 * (WGT_W+1)'(3);
      2'd2: r = (a <<< SQ_W) + (a2 <<< (FRAC_W + 2)) - a3 * (WGT_W+1)'(3);
      default: r = a3 - (a2 <<< FRAC_W);
    endcase
    return r[WGT_W-1:0];
  endfunction

  assign sx = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(fx);
  assign sy = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(fy);

  // Square, cube, then weights
  always_ff @(posedge clk) begin
    fx2 <= SQ_W'(fx) * SQ_W'(fx);
    fy2 <= SQ_W'(fy) * SQ_W'(fy);
    fx3 <= CU_W'(fx2) * CU_W'(fx);
    fy3 <= CU_W'(fy2) * CU_W'(fy);
    l0  <= LW_W'(sx) * LW_W'(sy);
    l1  <= LW_W'(fx) * LW_W'(sy);
    l2  <= LW_W'(sx) * LW_W'(fy);
    l3  <= LW_W'(fx) * LW_W'(fy);
    for (int k = 0; k < 4; k++) begin
      wx[k] <= cr_wgt(fx, fx2, fx3, 2'(k));
      wy[k] <= cr_wgt(fy, fy2, fy3, 2'(k));
    end
    wl[0] <= WGT_W'(l0);
    wl[1] <= WGT_W'(l1);
    wl[2] <= WGT_W'(l2);
    wl[3] <= WGT_W'(l3);
  end

endmodule

### rtl/core/iis_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_mac
// Multiply-accumulate pipeline: horizontal taps into rows, rows into result.
// ----------------------------------------------------------------------------
module iis_mac import iis_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tap_tag_t         tag,
  input  logic [PIX_W-1:0] rdata,
  input  logic [PIX_W-1:0] fill_pix,
  output logic             done,
  output logic [OUT_W-1:0] result
);

  localparam int PROD_W = WGT_W + PIX_W + 1;
  localparam int RACC_W = PROD_W + 2;
  localparam int P2_W   = WGT_W + ROW_W;
  localparam int ACC_W  = P2_W + 2;

  logic [PIX_W-1:0]         pix;
  tap_tag_t                 tag2;
  logic signed [PROD_W-1:0] prod;
  logic signed [RACC_W-1:0] row_acc, row_sum;
  logic signed [RACC_W-1:0] row_rnd, lin_rnd;
  logic signed [ROW_W-1:0]  row_r;
  logic                     row_vld, row_last;
  logic signed [WGT_W-1:0]  row_w;
  logic signed [P2_W-1:0]   prod2;
  logic                     p2_vld, p2_last;
  logic signed [ACC_W-1:0]  acc, acc_sum, acc_rnd;

  assign pix     = tag.fill ? fill_pix : rdata;
  assign row_sum = row_acc + RACC_W'(prod);
  assign row_rnd = (row_sum + (RACC_W'(1) <<< (2 * FRAC_W))) >>> (2 * FRAC_W + 1);
  assign lin_rnd = (row_sum + (RACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  assign acc_sum = acc + ACC_W'(prod2);
  assign acc_rnd = (acc_sum + (ACC_W'(1) <<< (3 * FRAC_W))) >>> (3 * FRAC_W + 1);

  // Multiply tap weight by pixel
  always_ff @(posedge clk) begin
    prod <= PROD_W'(tag.weight) * PROD_W'($signed({1'b0, pix}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.valid <= 1'b0;
    end else begin
      tag2 <= tag;
    end
  end

  // Accumulate taps; close a row or a whole linear sum
  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc <= '0;
      row_vld <= 1'b0;
      done    <= 1'b0;
      acc     <= '0;
      p2_vld  <= 1'b0;
    end else begin
      row_vld <= 1'b0;
      done    <= 1'b0;
      if (tag2.valid) begin
        if (tag2.row_end) begin
          row_acc <= '0;
          if (tag2.cubic) begin
            row_vld <= 1'b1;
          end else begin
            done <= 1'b1;
          end
        end else begin
          row_acc <= row_sum;
        end
      end
      p2_vld <= row_vld;
      // Accumulate weighted rows
      if (p2_vld) begin
        if (p2_last) begin
          acc  <= '0;
          done <= 1'b1;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  // Row payload and vertical product
  always_ff @(posedge clk) begin
    if (tag2.valid && tag2.row_end) begin
      row_r    <= row_rnd[ROW_W-1:0];
      row_w    <= tag2.row_weight;
      row_last <= tag2.last;
      if (!tag2.cubic) begin
        result <= sat_out(64'(lin_rnd));
      end
    end
    prod2   <= P2_W'(row_w) * P2_W'(row_r);
    p2_last <= row_last;
    if (p2_vld && p2_last) begin
      result <= sat_out(64'(acc_rnd));
    end
  end

endmodule

### rtl/core/image2d_interpolating_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image2d_interpolating_sampler_top
// 2D image store with nearest, bilinear and Catmull-Rom bicubic sampling.
//
//   port group  | direction | moves
//   req_*       | in        | pixel write or sample coordinate request
//   rsp_*       | out       | sample_value, one per sample request
//   cfg_*       | in        | register writes, index and data
//
// A write request is written to the image memory when it is accepted. A sample
// request passes the weight state, then 1, 4 or 16 reads (nearest, bilinear,
// bicubic) from the single-port image memory, one a cycle, then waits for the
// multiply-accumulate pipeline. Bound misses and the unused mode are answered
// without weights or reads.
// Reset clears control and registers; the image store is not cleared.
// A result waits in the output register while rsp_stall is high; the next
// request is taken meanwhile.
// ----------------------------------------------------------------------------
module image2d_interpolating_sampler_top import iis_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      cmd,
  input  logic [POS_W-1:0]          pixel_col,
  input  logic [POS_W-1:0]          pixel_row,
  input  logic [PIX_W-1:0]          pixel_value,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [OUT_W-1:0]          sample_value,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  iis_state_t state, state_next;

  logic [1:0]        interp_mode;
  logic              pad_mode;
  logic [PIX_W-1:0]  fill_value;
  logic              bound_check;
  logic [SIZE_W-1:0] image_width, image_height;
  logic [SIZE_W-1:0] eff_w, eff_h;

  logic signed [COORD_W-1:0] xr, yr;
  logic [1:0]                mode;
  logic [1:0]                cnt;
  logic [3:0]                tap;
  logic [OUT_W-1:0]          res_hold;
  logic                      accept, take_sample, early, out_free;
  logic [OUT_W-1:0]          early_val;

  logic signed [WGT_W-1:0] wx [4];
  logic signed [WGT_W-1:0] wy [4];
  logic signed [WGT_W-1:0] wl [4];

  logic signed [IDX_W-1:0] bx, by, nx, ny, col, row;
  logic signed [COORD_W:0] xs, ys;
  logic                    last_tap, col_out, row_out;
  logic [POS_W-1:0]        col_c, row_c;
  tap_tag_t                tag, tag1;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [PIX_W-1:0]        rdata;
  logic                    mac_done;
  logic [OUT_W-1:0]        mac_result;

  // Effective image size
  always_comb begin
    eff_w = (image_width == '0) ? SIZE_W'(1) :
            (image_width > MAX_SIZE) ? MAX_SIZE : image_width;
    eff_h = (image_height == '0) ? SIZE_W'(1) :
            (image_height > MAX_SIZE) ? MAX_SIZE : image_height;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode  <= MODE_NEAREST;
      pad_mode     <= 1'b0;
      fill_value   <= '0;
      bound_check  <= 1'b0;
      image_width  <= MAX_SIZE;
      image_height <= MAX_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERP: interp_mode  <= cfg_data[1:0];
        REG_PAD:    pad_mode     <= cfg_data[0];
        REG_FILL:   fill_value   <= cfg_data[PIX_W-1:0];
        REG_BOUND:  bound_check  <= cfg_data[0];
        REG_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept      = req_valid && !req_stall;
  assign req_stall   = (state != S_IDLE);
  assign take_sample = accept && (cmd == CMD_SAMPLE);
  assign out_free    = !rsp_valid || !rsp_stall;

  // Requests answered without reads: bound miss and unused mode
  always_comb begin
    early     = 1'b0;
    early_val = '0;
    if (bound_check && !pad_mode &&
        (coord_x < 0 || coord_y < 0 ||
         coord_x[COORD_W-2:0] >
           (COORD_W-1)'({eff_w - SIZE_W'(1), {FRAC_W{1'b0}}}) ||
         coord_y[COORD_W-2:0] >
           (COORD_W-1)'({eff_h - SIZE_W'(1), {FRAC_W{1'b0}}}))) begin
      early     = 1'b1;
      early_val = OUT_W'({fill_value, {FRAC_W{1'b0}}});
    end else if (interp_mode != MODE_NEAREST && interp_mode != MODE_LINEAR &&
                 interp_mode != MODE_CUBIC) begin
      early = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take_sample) state_next = early ? S_DONE : S_WGT;
      end
      S_WGT: begin
        if (cnt == 2'd2) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (last_tap) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (mac_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Capture request, count weight cycles and taps, hold result
  always_ff @(posedge clk) begin
    if (take_sample) begin
      xr   <= coord_x;
      yr   <= coord_y;
      mode <= interp_mode;
      if (early) res_hold <= early_val;
    end
    if (state == S_WAIT && mac_done) res_hold <= mac_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      tap <= '0;
    end else begin
      cnt <= (state == S_WGT) ? cnt + 2'd1 : 2'd0;
      tap <= (state == S_FETCH) ? tap + 4'd1 : 4'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) sample_value <= res_hold;
  end

  // Base, nearest and neighbor indexes
  assign bx = IDX_W'(xr >>> FRAC_W);
  assign by = IDX_W'(yr >>> FRAC_W);
  assign xs = (COORD_W+1)'(xr) + (COORD_W+1)'(1 << (FRAC_W - 1));
  assign ys = (COORD_W+1)'(yr) + (COORD_W+1)'(1 << (FRAC_W - 1));
  assign nx = IDX_W'(xs >>> FRAC_W);
  assign ny = IDX_W'(ys >>> FRAC_W);

  always_comb begin
    tag            = '0;
    tag.cubic      = (mode == MODE_CUBIC);
    tag.row_weight = wy[tap[3:2]];
    priority case (mode)
      MODE_CUBIC: begin
        col         = bx + IDX_W'(tap[1:0]) - IDX_W'(1);
        row         = by + IDX_W'(tap[3:2]) - IDX_W'(1);
        tag.weight  = wx[tap[1:0]];
        tag.row_end = (tap[1:0] == 2'd3);
        last_tap    = (tap == 4'd15);
      end
      MODE_LINEAR: begin
        col         = bx + IDX_W'(tap[0]);
        row         = by + IDX_W'(tap[1]);
        tag.weight  = wl[tap[1:0]];
        tag.row_end = (tap[1:0] == 2'd3);
        last_tap    = (tap[1:0] == 2'd3);
      end
      default: begin
        col         = nx;
        row         = ny;
        tag.weight  = WGT_W'(1 << (2 * FRAC_W));
        tag.row_end = 1'b1;
        last_tap    = 1'b1;
      end
    endcase
    tag.valid = (state == S_FETCH);
    tag.last  = last_tap;
    col_out   = (col < 0) || (col >= $signed(IDX_W'(eff_w)));
    row_out   = (row < 0) || (row >= $signed(IDX_W'(eff_h)));
    tag.fill  = pad_mode && (col_out || row_out);
    col_c = (col < 0) ? '0 :
            (col >= $signed(IDX_W'(eff_w))) ? POS_W'(eff_w - SIZE_W'(1)) : col[POS_W-1:0];
    row_c = (row < 0) ? '0 :
            (row >= $signed(IDX_W'(eff_h))) ? POS_W'(eff_h - SIZE_W'(1)) : row[POS_W-1:0];
  end

  // Memory port: write requests in idle, reads while fetching
  assign mem_we   = accept && (cmd == CMD_WRITE);
  assign mem_addr = mem_we ? {pixel_row, pixel_col} : {row_c, col_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag;
    end
  end

  iis_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (pixel_value),
    .rdata (rdata)
  );

  iis_wgt u_wgt (
    .clk (clk),
    .fx  (xr[FRAC_W-1:0]),
    .fy  (yr[FRAC_W-1:0]),
    .wx  (wx),
    .wy  (wy),
    .wl  (wl)
  );

  iis_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag1),
    .rdata    (rdata),
    .fill_pix (fill_value),
    .done     (mac_done),
    .result   (mac_result)
  );

  // A finished sum only arrives while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_WAIT)
    else $error("result arrived outside wait state");

  // No pixel write lands during a fetch sequence
  a_no_write_in_fetch: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_IDLE)
    else $error("image write outside idle");

  // A read issued for the last tap is followed by the wait state
  a_last_to_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && last_tap) |=> state == S_WAIT)
    else $error("fetch did not end after last tap");

endmodule

### tb/sv/image2d_interpolating_sampler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image2d_interpolating_sampler_top_tb
// Self-checking bench for the interpolating image sampler. A scoreboard keeps
// its own copy of the image and the registers and predicts every sample in
// nearest, bilinear and bicubic mode under both pad modes and the bound check.
// Phases cycle through image sizes (from 1x1 to 256 wide or tall) and through
// idle and stall patterns, with one long response hold-off.
// ----------------------------------------------------------------------------
module image2d_interpolating_sampler_top_tb;
  import iis_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint ONE = 64'sd1 <<< FRAC_W;

  // Predicts sample results from a mirror of the image and registers
  class sampler_scoreboard;
    logic [PIX_W-1:0]  pix [65536];
    bit                written [65536];
    logic [1:0]        mode;
    logic              pad;
    logic [15:0]       fill;
    logic              bound;
    logic [SIZE_W-1:0] wreg;
    logic [SIZE_W-1:0] hreg;
    logic [OUT_W-1:0]  pending [$];
    int                errors;
    int                writes;
    int                samples [4];

    function new();
      mode = MODE_NEAREST;
      pad = 1'b0;
      fill = '0;
      bound = 1'b0;
      wreg = MAX_SIZE;
      hreg = MAX_SIZE;
      errors = 0;
      writes = 0;
      foreach (samples[i]) samples[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_INTERP: mode = d[1:0];
        REG_PAD:    pad = d[0];
        REG_FILL:   fill = d;
        REG_BOUND:  bound = d[0];
        REG_WIDTH:  wreg = d[SIZE_W-1:0];
        REG_HEIGHT: hreg = d[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff(logic [SIZE_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_SIZE) return int'(MAX_SIZE);
      return int'(r);
    endfunction

    // Pixel with edge replication or fill padding
    function longint pel(longint ix, longint iy);
      longint w;
      longint h;
      w = eff(wreg);
      h = eff(hreg);
      if (ix < 0 || ix >= w || iy < 0 || iy >= h) begin
        if (pad) return longint'(fill);
        if (ix < 0) ix = 0;
        if (ix >= w) ix = w - 1;
        if (iy < 0) iy = 0;
        if (iy >= h) iy = h - 1;
      end
      return longint'(pix[iy * 256 + ix]);
    endfunction

    // Catmull-Rom tap weight k, scaled by 2 S^3
    function longint cr_weight(longint f, int k);
      longint s2;
      longint f2;
      longint f3;
      s2 = ONE * ONE;
      f2 = f * f;
      f3 = f2 * f;
      case (k)
        0: return 2 * f2 * ONE - f * s2 - f3;
        1: return 2 * ONE * s2 - 5 * f2 * ONE + 3 * f3;
        2: return f * s2 + 4 * f2 * ONE - 3 * f3;
        default: return f3 - f2 * ONE;
      endcase
    endfunction

    function longint interpolate(longint x, longint y);
      longint bx;
      longint by;
      longint fx;
      longint fy;
      longint acc;
      longint rowv;
      if (bound && !pad) begin
        if (x < 0 || y < 0 || x > (eff(wreg) - 1) * ONE || y > (eff(hreg) - 1) * ONE)
          return longint'(fill) <<< FRAC_W;
      end
      if (mode == MODE_NEAREST)
        return pel((x + ONE / 2) >>> FRAC_W, (y + ONE / 2) >>> FRAC_W) <<< FRAC_W;
      bx = x >>> FRAC_W;
      by = y >>> FRAC_W;
      fx = x - bx * ONE;
      fy = y - by * ONE;
      if (mode == MODE_LINEAR) begin
        acc = (ONE - fx) * (ONE - fy) * pel(bx, by) + (ONE - fx) * fy * pel(bx, by + 1)
            + fx * (ONE - fy) * pel(bx + 1, by) + fx * fy * pel(bx + 1, by + 1);
        return (acc + ONE / 2) >>> FRAC_W;
      end
      if (mode == MODE_CUBIC) begin
        acc = 0;
        for (int i = 0; i < 4; i++) begin
          rowv = 0;
          for (int j = 0; j < 4; j++)
            rowv += cr_weight(fx, j) * pel(bx - 1 + j, by - 1 + i);
          rowv = (rowv + (64'sd1 <<< (2 * FRAC_W))) >>> (2 * FRAC_W + 1);
          acc += cr_weight(fy, i) * rowv;
        end
        return (acc + (64'sd1 <<< (3 * FRAC_W))) >>> (3 * FRAC_W + 1);
      end
      return 0;
    endfunction

    // Note an accepted request: store a pixel or queue the expected sample
    function void note_req(logic c, logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                           logic [PIX_W-1:0] val, logic signed [COORD_W-1:0] cx,
                           logic signed [COORD_W-1:0] cy);
      longint v;
      if (c == CMD_WRITE) begin
        pix[{row, col}] = val;
        written[{row, col}] = 1'b1;
        writes++;
        return;
      end
      v = interpolate(longint'(cx), longint'(cy));
      if (v > (64'sd1 <<< (OUT_W - 1)) - 1) v = (64'sd1 <<< (OUT_W - 1)) - 1;
      if (v < -(64'sd1 <<< (OUT_W - 1))) v = -(64'sd1 <<< (OUT_W - 1));
      pending.push_back(v[OUT_W-1:0]);
      samples[mode]++;
    endfunction

    function void check_rsp(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending.size() == 0) begin
        $error("sample_value: unexpected response, actual %0h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("sample_value: expected %0h, actual %0h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_stall;
  logic                      cmd;
  logic [POS_W-1:0]          pixel_col;
  logic [POS_W-1:0]          pixel_row;
  logic [PIX_W-1:0]          pixel_value;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic                      rsp_valid;
  logic                      rsp_stall;
  logic [OUT_W-1:0]          sample_value;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  sampler_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_cycles;

  image2d_interpolating_sampler_top i_dut (.*);

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Drive response stall: random, or held for a requested stretch
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check responses as they are accepted
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_rsp(sample_value);
  end

  // Overall time limit
  initial begin
    #20ms;
    $display("** image2d_interpolating_sampler_top: FAILED **");
    $finish;
  end

  // Offer one request, with random idle before it, and wait for acceptance
  task automatic send_req(logic c, logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                          logic [PIX_W-1:0] val, int cx, int cy);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    cmd = c;
    pixel_col = col;
    pixel_row = row;
    pixel_value = val;
    coord_x = cx[COORD_W-1:0];
    coord_y = cy[COORD_W-1:0];
    do @(posedge clk); while (req_stall);
    sb.note_req(c, col, row, val, coord_x, coord_y);
  endtask

  task automatic send_sample(int cx, int cy);
    send_req(CMD_SAMPLE, POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom), cx, cy);
  endtask

  task automatic send_write(int col, int row, logic [PIX_W-1:0] val);
    send_req(CMD_WRITE, col[POS_W-1:0], row[POS_W-1:0], val, $urandom, $urandom);
  endtask

  // Drain outstanding samples, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic set_config(logic [1:0] m, logic p, logic [15:0] f, logic b,
                            logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(REG_INTERP, CFG_W'(m));
    write_reg(REG_PAD, CFG_W'(p));
    write_reg(REG_FILL, f);
    write_reg(REG_BOUND, CFG_W'(b));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Write every pixel of the active image not yet written, or every pixel for extremes
  task automatic fill_image(bit extremes);
    int w;
    int h;
    logic [PIX_W-1:0] v;
    w = sb.eff(sb.wreg);
    h = sb.eff(sb.hreg);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (extremes || !sb.written[r * 256 + c]) begin
          v = extremes ? (((r + c) % 2 == 0) ? 16'hFFFF : 16'h0000) : 16'($urandom);
          send_write(c, r, v);
        end
  endtask

  // Coordinate around the image on one axis, sometimes anywhere in range
  function automatic int pick_coord(int size);
    if ($urandom_range(9) == 0) return int'(signed'(20'($urandom)));
    return int'($urandom_range(0, (size + 3) * 256)) - 512;
  endfunction

  int w;
  int h;
  int big;
  logic [CFG_W-1:0] wsel;
  logic [CFG_W-1:0] hsel;

  initial begin
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    cmd = CMD_WRITE;
    pixel_col = '0;
    pixel_row = '0;
    pixel_value = '0;
    coord_x = '0;
    coord_y = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: 4x4 checkerboard of extreme pixels
    set_config(MODE_NEAREST, 1'b0, 16'hFFFF, 1'b0, 16'd4, 16'd4);
    write_reg(REG_UNUSED, 16'hFFFF);
    fill_image(1'b1);
    send_sample(0, 0);
    send_sample(128, 128);
    send_sample(127, 383);
    send_sample(-524288, 524287);
    set_config(MODE_LINEAR, 1'b0, 16'hFFFF, 1'b0, 16'd4, 16'd4);
    send_sample(64, 192);
    send_sample(-100, 900);
    send_sample(524287, -524288);
    set_config(MODE_CUBIC, 1'b0, 16'hFFFF, 1'b0, 16'd4, 16'd4);
    send_sample(128, 128);
    send_sample(255, 1);
    send_sample(-1, 767);
    set_config(MODE_CUBIC, 1'b1, 16'hFFFF, 1'b0, 16'd4, 16'd4);
    send_sample(-128, 300);
    send_sample(700, 800);
    set_config(MODE_LINEAR, 1'b0, 16'hABCD, 1'b1, 16'd4, 16'd4);
    send_sample(768, 768);
    send_sample(769, 0);
    send_sample(-1, 0);
    set_config(MODE_UNUSED, 1'b0, 16'h0000, 1'b0, 16'd4, 16'd4);
    send_sample(256, 256);
    // Size register out of range: zero acts as one, large saturates
    set_config(MODE_NEAREST, 1'b0, 16'h0000, 1'b0, 16'd0, 16'hFFFF);
    fill_image(1'b0);
    send_sample(200, 65535);
    send_sample(-300, 66000);

    // Random phases
    for (int p = 0; p < 28; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      big = $urandom_range(6);
      wsel = 16'($urandom_range(1, 12));
      hsel = 16'($urandom_range(1, 12));
      if (big == 0) begin wsel = 16'd256; hsel = 16'($urandom_range(0, 1)); end
      if (big == 1) begin hsel = 16'hFFFF; wsel = 16'($urandom_range(0, 1)); end
      set_config($urandom_range(9) == 0 ? MODE_UNUSED : 2'($urandom_range(2)),
                 1'($urandom),
                 $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom), 1'($urandom),
                 wsel, hsel);
      fill_image(1'b0);
      w = sb.eff(sb.wreg);
      h = sb.eff(sb.hreg);
      if (p == 6) hold_cycles = 400;
      for (int k = 0; k < 24; k++) begin
        if ($urandom_range(9) == 0)
          send_write($urandom_range(w - 1), $urandom_range(h - 1), 16'($urandom));
        else
          send_sample(pick_coord(w), pick_coord(h));
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Covered %0d pixel writes; samples nearest %0d, bilinear %0d, bicubic %0d,",
             sb.writes, sb.samples[0], sb.samples[1], sb.samples[2]);
    $display("unused mode %0d, over 28 random register settings and idle patterns.",
             sb.samples[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** image2d_interpolating_sampler_top: PASSED **");
    end else begin
      $display("** image2d_interpolating_sampler_top: FAILED **");
    end
    $finish;
  end

endmodule

### image2d_interpolating_sampler_top.f
rtl/core/iis_pkg.sv
rtl/core/iis_mem.sv
rtl/core/iis_wgt.sv
rtl/core/iis_mac.sv
rtl/core/image2d_interpolating_sampler_top.sv
tb/sv/image2d_interpolating_sampler_top_tb.sv
